@@ hdl/esp_pkg.sv @@
// Shared constants for the elementary symmetric polynomial block.
package esp_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CoefW     = 64;
  localparam int unsigned OrderW    = 6;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  // Register index, taken from paddr[2] (byte address 4*i)
  localparam logic RegOrder = 1'b0;

  localparam logic [OrderW-1:0] OrderReset = OrderW'(1);
  localparam logic [CoefW-1:0]  OneQ32     = CoefW'(64'h0000_0001_0000_0000);
  localparam logic [CoefW-1:0]  SatMax     = {CoefW{1'b1}};

endpackage

@@ hdl/esp_in_if.sv @@
// Input stream channel: one value per beat with a last mark.
interface esp_in_if;
  logic                          valid;
  logic                          ready;
  logic [esp_pkg::ValueW-1:0]    value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

@@ hdl/esp_out_if.sv @@
// Result stream channel: polynomial value and overflow flag.
interface esp_out_if;
  logic                          valid;
  logic                          ready;
  logic [esp_pkg::CoefW-1:0]     sum_value;
  logic                          overflow;

  modport source (output valid, output sum_value, output overflow, input ready);
  modport sink   (input valid, input sum_value, input overflow, output ready);
endinterface

@@ hdl/elementary_symmetric_poly_kth_top.sv @@
// Each beat is registered, then folded into the coefficients; a last beat loads the result register.
// One beat per cycle unless stalled; all K_MAX coefficients update at once via per-lane MACs.
// A stall occurs only when a last beat waits on a full, unaccepted result register.
// Reset (async, active low): c[0] = 1.0, other coefficients 0, flag clear, order = 1.
// After each last beat the coefficients and overflow flag return to that reset state.
module elementary_symmetric_poly_kth_top #(
  parameter int unsigned K_MAX = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  esp_in_if.sink                          in_i,
  esp_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [esp_pkg::ApbAddrW-1:0]    paddr,
  input  logic [esp_pkg::ApbDataW-1:0]    pwdata,
  output logic [esp_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned KW = $clog2(K_MAX + 1);

  // config register
  logic [esp_pkg::OrderW-1:0] order_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= esp_pkg::OrderReset;
    end else if (cfg_wr && (paddr[2] == esp_pkg::RegOrder)) begin
      order_q <= pwdata[esp_pkg::OrderW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == esp_pkg::RegOrder) begin
      prdata = esp_pkg::ApbDataW'(order_q);
    end
  end

  // input register
  logic                        s1_valid_q;
  logic                        s1_last_q;
  logic [esp_pkg::ValueW-1:0]  s1_value_q;
  logic                        s1_fire;
  logic                        out_free;
  logic                        in_ready;

  // result register
  logic                        out_valid_q;
  logic [esp_pkg::CoefW-1:0]   out_sum_q;
  logic                        out_ovf_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready = !s1_valid_q || s1_fire;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_value_q <= in_i.value;
      s1_last_q  <= in_i.last;
    end
  end

  // coefficient lanes: lane n holds c[n+1]; c[0] is the constant 1.0
  logic [esp_pkg::CoefW-1:0] coef_q    [K_MAX];
  logic [esp_pkg::CoefW-1:0] coef_nx   [K_MAX];
  logic [esp_pkg::CoefW-1:0] prev_c    [K_MAX];
  logic [esp_pkg::CoefW-1:0] hi_prod   [K_MAX];
  logic [esp_pkg::CoefW-1:0] lo_prod   [K_MAX];
  logic [esp_pkg::CoefW:0]   mul_sum   [K_MAX];
  logic [esp_pkg::CoefW-1:0] prod_sat  [K_MAX];
  logic [esp_pkg::CoefW:0]   acc_sum   [K_MAX];
  logic [K_MAX-1:0]          lane_sat;
  logic                      sat_q;

  always_comb begin
    for (int n = 0; n < K_MAX; n++) begin
      prev_c[n]  = (n == 0) ? esp_pkg::OneQ32 : coef_q[(n == 0) ? 0 : n - 1];
      hi_prod[n] = 64'(prev_c[n][63:32]) * 64'(s1_value_q);
      lo_prod[n] = 64'(prev_c[n][31:0]) * 64'(s1_value_q);
      mul_sum[n] = {1'b0, hi_prod[n][47:0], 16'b0} + 65'(lo_prod[n][63:16]);
      prod_sat[n] = ((hi_prod[n][63:48] != '0) || mul_sum[n][64]) ?
                    esp_pkg::SatMax : mul_sum[n][63:0];
      acc_sum[n] = 65'(coef_q[n]) + 65'(prod_sat[n]);
      lane_sat[n] = (hi_prod[n][63:48] != '0) || mul_sum[n][64] || acc_sum[n][64];
      coef_nx[n] = acc_sum[n][64] ? esp_pkg::SatMax : acc_sum[n][63:0];
    end
  end

  // effective order and result select
  logic [KW-1:0]             k_eff;
  logic [esp_pkg::CoefW-1:0] result;
  logic                      sat_nx;

  always_comb begin
    if (int'(order_q) > int'(K_MAX)) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(order_q);
    end
  end

  always_comb begin
    result = esp_pkg::OneQ32;
    sat_nx = sat_q;
    for (int n = 0; n < K_MAX; n++) begin
      if (k_eff == KW'(n + 1)) begin
        result = coef_nx[n];
      end
      if (lane_sat[n] && (KW'(n) < k_eff)) begin
        sat_nx = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < K_MAX; n++) begin
        coef_q[n] <= '0;
      end
      sat_q <= 1'b0;
    end else if (s1_fire) begin
      for (int n = 0; n < K_MAX; n++) begin
        coef_q[n] <= s1_last_q ? '0 : coef_nx[n];
      end
      sat_q <= s1_last_q ? 1'b0 : sat_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_sum_q <= result;
      out_ovf_q <= sat_nx;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sum_value = out_sum_q;
  assign out_o.overflow  = out_ovf_q;

`ifndef ASSERT_OFF
  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> out_valid_q)
    else $error("last beat did not load the result register");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> (coef_q[0] == '0) && !sat_q)
    else $error("coefficients not cleared after last beat");

  a_coef_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_last_q |=> coef_q[0] >= $past(coef_q[0]))
    else $error("coefficient decreased within a set");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> s1_valid_q && s1_last_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a blocked result");
`endif

endmodule

@@ verif/esp_poly_checker.sv @@
// Predicts elementary symmetric polynomial results and checks them beat by beat.
module esp_poly_checker #(
  parameter int unsigned KMax = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  esp_in_if                            in_mon,
  esp_out_if                           out_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esp_pkg::ApbAddrW-1:0] paddr,
  input  logic [esp_pkg::ApbDataW-1:0] pwdata,
  input  logic [esp_pkg::ApbDataW-1:0] prdata,
  input  logic                         pready,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic [esp_pkg::CoefW-1:0] sum_value;
    logic                      overflow;
  } poly_result_t;

  logic [esp_pkg::CoefW-1:0]  coef_q [KMax+1];
  logic                       sat_q;
  logic [esp_pkg::OrderW-1:0] order_q;
  poly_result_t               expected_q [$];
  int                         mismatch_count = 0;
  int                         outstanding = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = outstanding;

  task automatic report_mismatch(input string what, input logic [esp_pkg::CoefW-1:0] got,
                                 input logic [esp_pkg::CoefW-1:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_poly();
    for (int j = 0; j <= KMax; j++) coef_q[j] = '0;
    coef_q[0] = esp_pkg::OneQ32;
    sat_q     = 1'b0;
  endtask

  // Multiply the running polynomial by (1 + x*z); old coefficients feed each lane.
  task automatic fold_value(input logic [esp_pkg::ValueW-1:0] x, input logic last);
    logic [esp_pkg::CoefW+esp_pkg::ValueW-1:0] prod;
    logic [esp_pkg::CoefW:0]                   acc;
    logic [esp_pkg::CoefW-1:0]                 term;
    logic                                      hit;
    int unsigned                               k;
    poly_result_t                              res;
    k = (order_q > KMax) ? KMax : order_q;
    for (int j = KMax; j >= 1; j--) begin
      hit  = 1'b0;
      prod = (esp_pkg::CoefW+esp_pkg::ValueW)'(coef_q[j-1]) *
             (esp_pkg::CoefW+esp_pkg::ValueW)'(x);
      // Q48.48 -> Q32.32, saturate if anything is left above bit 79
      if (prod[esp_pkg::CoefW+esp_pkg::ValueW-1:esp_pkg::CoefW+16] != '0) begin
        term = esp_pkg::SatMax;
        hit  = 1'b1;
      end else begin
        term = prod[esp_pkg::CoefW+15:16];
      end
      acc = {1'b0, coef_q[j]} + {1'b0, term};
      if (acc[esp_pkg::CoefW]) begin
        coef_q[j] = esp_pkg::SatMax;
        hit       = 1'b1;
      end else begin
        coef_q[j] = acc[esp_pkg::CoefW-1:0];
      end
      if (hit && j <= k) sat_q = 1'b1;
    end
    if (last) begin
      res.sum_value = coef_q[k];
      res.overflow  = sat_q;
      expected_q.push_back(res);
      clear_poly();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_poly();
      order_q = esp_pkg::OrderReset;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", out_mon.sum_value, '0);
        end else begin
          poly_result_t want;
          want = expected_q.pop_front();
          if (out_mon.sum_value !== want.sum_value)
            report_mismatch("sum_value", out_mon.sum_value, want.sum_value);
          if (out_mon.overflow !== want.overflow)
            report_mismatch("overflow", esp_pkg::CoefW'(out_mon.overflow),
                            esp_pkg::CoefW'(want.overflow));
        end
      end
      if (psel && penable && pready && paddr[2] == esp_pkg::RegOrder) begin
        if (pwrite) order_q = pwdata[esp_pkg::OrderW-1:0];
        else if (prdata !== esp_pkg::ApbDataW'(order_q))
          report_mismatch("order readback", esp_pkg::CoefW'(prdata),
                          esp_pkg::CoefW'(order_q));
      end
      if (in_mon.valid && in_mon.ready) fold_value(in_mon.value, in_mon.last);
    end
    outstanding = expected_q.size();
  end

endmodule

@@ verif/elementary_symmetric_poly_kth_top_tb.sv @@
// Stimulus and verdict for the elementary symmetric polynomial block.
module elementary_symmetric_poly_kth_top_tb;

  localparam int unsigned KMax       = 32;
  localparam int          CycleLimit = 200000;
  localparam int          LongHold   = 150;
  localparam int          PhaseItems = 60;
  localparam int          NumPhases  = 10;
  localparam int          SettleCyc  = 4;
  localparam logic [esp_pkg::ApbAddrW-1:0] OrderAddr = {esp_pkg::RegOrder, 2'b00};
  localparam logic [esp_pkg::ApbAddrW-1:0] SpareAddr = {~esp_pkg::RegOrder, 2'b00};

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [esp_pkg::ApbAddrW-1:0] paddr;
  logic [esp_pkg::ApbDataW-1:0] pwdata;
  logic [esp_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  esp_in_if  in_if ();
  esp_out_if out_if ();

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  bit          idle_on = 1'b0;
  bit          long_hold_req = 1'b0;
  int          sink_hold = 0;
  int          set_left = 0;
  int unsigned cur_order = 32'(esp_pkg::OrderReset);

  elementary_symmetric_poly_kth_top #(.K_MAX(KMax)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  esp_poly_checker #(.KMax(KMax)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("elementary_symmetric_poly_kth_top_tb failed");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        sink_hold     = LongHold;
      end else if (sink_hold == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 7);
      end
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [esp_pkg::ValueW-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      4:       return $urandom_range(0, 32'h0000_FFFF);
      default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
    endcase
  endfunction

  // Mostly long enough to reach the order, sometimes short of it.
  function automatic int new_set_len(input int unsigned order);
    int unsigned k;
    k = (order > KMax) ? KMax : order;
    if ($urandom_range(0, 4) == 0) return $urandom_range(1, k + 1);
    return $urandom_range((k > 0) ? k : 1, k + 6);
  endfunction

  task automatic send_beat(input logic [esp_pkg::ValueW-1:0] value, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.last  <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_stream(input int count);
    for (int i = 0; i < count; i++) begin
      if (set_left == 0) set_left = new_set_len(cur_order);
      set_left--;
      send_beat(random_value(), set_left == 0);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [esp_pkg::ApbAddrW-1:0] addr,
                           input logic [esp_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == OrderAddr) cur_order = 32'(data[esp_pkg::OrderW-1:0]);
    @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [esp_pkg::ApbAddrW-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_order(input int unsigned order);
    wait_idle();
    write_reg(OrderAddr, esp_pkg::ApbDataW'(order));
    read_reg(OrderAddr);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    in_if.last   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // order at reset value: single 1.0, then two full-scale values
    send_beat(32'h0001_0000, 1'b1);
    send_beat('1, 1'b0);
    send_beat('1, 1'b1);
    // order 2 with full-scale values saturates
    set_order(2);
    repeat (2) send_beat('1, 1'b0);
    send_beat('1, 1'b1);
    // order zero gives the empty product
    set_order(0);
    send_beat(32'h0003_0000, 1'b1);
    // fewer values than the order
    set_order(3);
    send_beat(32'h0002_0000, 1'b0);
    send_beat('0, 1'b1);
    // order above the maximum clamps; spare address write is ignored
    set_order(63);
    write_reg(SpareAddr, 32'd5);
    read_reg(OrderAddr);
    send_beat(32'h0001_0000, 1'b0);
    send_beat(32'h0001_0000, 1'b1);
    // order changed in the middle of a set
    set_order(2);
    send_beat(32'h0001_8000, 1'b0);
    send_beat(32'h0000_0001, 1'b0);
    set_order(1);
    send_beat(32'h0000_FFFF, 1'b1);
    // all-zero values
    set_order(2);
    send_beat('0, 1'b0);
    send_beat('0, 1'b1);

    // Sets may straddle phases, so the order also changes mid-set here.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       set_order(KMax);
        1:       set_order(1);
        2:       set_order(2);
        3:       set_order(0);
        4:       set_order($urandom_range(3, KMax - 1));
        5:       set_order(40);
        6:       set_order($urandom_range(2, 12));
        7:       set_order($urandom_range(13, KMax - 1));
        8:       set_order(5);
        default: set_order($urandom_range(0, KMax));
      endcase
      idle_on = (p != NumPhases - 1) && (p != 2) && ($urandom_range(0, 3) != 0);
      if (p == 2) long_hold_req = 1'b1;
      send_stream(PhaseItems);
    end
    while (set_left > 0) begin
      set_left--;
      send_beat(random_value(), set_left == 0);
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("elementary_symmetric_poly_kth_top_tb passed");
    end else begin
      $display("elementary_symmetric_poly_kth_top_tb failed");
    end
    $finish;
  end

endmodule
